FILE: rtl/core/assert_macros.svh
// Assertion macros for the checker of the handle allocator.
// Needs nothing else; include this file where the macros are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When the antecedent holds, the consequent holds in the same cycle.
`define GHA_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define GHA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/gha_pkg.sv
// Package of the generational handle allocator: opcode and status codes,
// the register width and reset value, and the controller/datapath structs.
// Depends on nothing.
package gha_pkg;

    // Configuration register.
    localparam int              CFG_WIDTH    = 13;
    localparam logic [12:0]     THRESH_RESET = 13'd1024;

    // Request opcodes.
    typedef logic [1:0] gha_op_t;
    localparam gha_op_t OP_CREATE  = 2'd0;
    localparam gha_op_t OP_DESTROY = 2'd1;
    localparam gha_op_t OP_QUERY   = 2'd2;
    localparam gha_op_t OP_CLEAR   = 2'd3;

    // Result status codes.
    typedef logic [1:0] gha_status_code_t;
    localparam gha_status_code_t ST_OK        = 2'd0;
    localparam gha_status_code_t ST_NO_INDEX  = 2'd1;
    localparam gha_status_code_t ST_NOT_ALIVE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // request transfer: latch it and start the reads
        logic reuse_rd;  // read the generation of the index at the queue head
        logic commit;    // write back state and load the result register
    } gha_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_reuse; // the pending create takes an index from the queue
        logic out_stall;  // the result register is full and not being taken
    } gha_dp_status_t;

endpackage

FILE: rtl/core/gha_ifs.sv
// Valid/ready channel interfaces of the handle allocator: configuration,
// request and result. Depends on gha_pkg.
interface gha_cfg_if import gha_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_WIDTH-1:0] reuse_threshold;

    modport source (output valid, output reuse_threshold, input ready);
    modport sink (input valid, input reuse_threshold, output ready);
endinterface

interface gha_req_if import gha_pkg::*; #(
    parameter int HANDLE_WIDTH = 20
) ();
    logic                    valid;
    logic                    ready;
    gha_op_t                 opcode;
    logic [HANDLE_WIDTH-1:0] handle_in;

    modport source (output valid, output opcode, output handle_in, input ready);
    modport sink (input valid, input opcode, input handle_in, output ready);
endinterface

interface gha_rsp_if import gha_pkg::*; #(
    parameter int HANDLE_WIDTH = 20,
    parameter int COUNT_WIDTH  = 13
) ();
    logic                    valid;
    logic                    ready;
    logic [HANDLE_WIDTH-1:0] handle_out;
    logic                    is_alive;
    gha_status_code_t        status;
    logic [COUNT_WIDTH-1:0]  live_count;

    modport source (output valid, output handle_out, output is_alive, output status,
                    output live_count, input ready);
    modport sink (input valid, input handle_out, input is_alive, input status,
                  input live_count, output ready);
endinterface

FILE: rtl/core/gha_ctrl.sv
// Controller of the handle allocator: sequences accept, lookup, the extra
// generation read for a reused index, and write-back. Depends on gha_pkg.
module gha_ctrl import gha_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  gha_dp_status_t dp_status,
    output gha_cmd_t       cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOOKUP = 2'd1;
    localparam logic [1:0] S_REUSE  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // A new request is taken only between requests.
    assign req_ready = (state_reg == S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.reuse_rd = 1'b0;
        cmd.commit   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (dp_status.need_reuse)
                begin
                    cmd.reuse_rd = 1'b1;
                    state_next   = S_REUSE;
                end
                else if (!dp_status.out_stall)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_REUSE:
            begin
                if (!dp_status.out_stall)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/gha_datapath.sv
// Datapath of the handle allocator: generation memory, free-index queue,
// counters, threshold register and result register. Depends on gha_pkg.
module gha_datapath import gha_pkg::*; #(
    parameter int INDEX_WIDTH = 12,
    parameter int GEN_WIDTH   = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  gha_cmd_t                         cmd,
    output gha_dp_status_t                   dp_status,
    input  gha_op_t                          req_opcode,
    input  logic [INDEX_WIDTH+GEN_WIDTH-1:0] req_handle,
    input  logic                             cfg_valid,
    input  logic [CFG_WIDTH-1:0]             cfg_data,
    input  logic                             rsp_ready,
    output logic                             rsp_valid,
    output logic [INDEX_WIDTH+GEN_WIDTH-1:0] rsp_handle,
    output logic                             rsp_is_alive,
    output gha_status_code_t                 rsp_status,
    output logic [INDEX_WIDTH:0]             rsp_live_count
);

    localparam int IW    = INDEX_WIDTH;
    localparam int GW    = GEN_WIDTH;
    localparam int HW    = IW + GW;
    localparam int CW    = IW + 1;
    localparam int DEPTH = 1 << IW;
    localparam int CMP_W = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;
    localparam logic [CW-1:0] SLOT_COUNT = {1'b1, {IW{1'b0}}};

    // Memories.
    logic [GW-1:0] gen_mem  [DEPTH];
    logic [IW-1:0] fifo_mem [DEPTH];

    // Latched request and memory read data.
    gha_op_t       op_reg;
    logic [HW-1:0] handle_reg;
    logic [GW-1:0] gen_rd_reg;
    logic [IW-1:0] fifo_rd_reg;

    // Counters and pointers.
    logic [IW-1:0]        fifo_head_reg, fifo_head_next;
    logic [IW-1:0]        fifo_tail_reg, fifo_tail_next;
    logic [CW-1:0]        fifo_count_reg, fifo_count_next;
    logic [CW-1:0]        fresh_next_reg, fresh_next_next;
    logic [CW-1:0]        live_total_reg, live_total_next;
    logic [CFG_WIDTH-1:0] threshold_reg;

    // Result register.
    logic             rsp_valid_reg;
    logic [HW-1:0]    rsp_handle_reg, rsp_handle_next;
    logic             rsp_alive_reg, rsp_alive_next;
    gha_status_code_t rsp_status_reg, rsp_status_next;
    logic [CW-1:0]    rsp_live_reg;

    // Memory port controls.
    logic          gen_we;
    logic [IW-1:0] gen_waddr;
    logic [GW-1:0] gen_wdata;
    logic          gen_re;
    logic [IW-1:0] gen_raddr;
    logic          fifo_we;

    // Decode of the pending request.
    logic [IW-1:0] req_idx;
    logic [GW-1:0] req_gen;
    logic          over_threshold;
    logic          fresh_avail;
    logic          create_pop;
    logic          handle_alive;
    logic [CW-1:0] live_dec;

    assign req_idx        = handle_reg[IW-1:0];
    assign req_gen        = handle_reg[HW-1:IW];
    assign over_threshold = CMP_W'(fifo_count_reg) > CMP_W'(threshold_reg);
    assign fresh_avail    = fresh_next_reg < SLOT_COUNT;
    assign create_pop     = over_threshold || (!fresh_avail && (fifo_count_reg != '0));
    assign handle_alive   = (live_total_reg != '0) && ({1'b0, req_idx} < fresh_next_reg)
                            && (gen_rd_reg == req_gen);
    assign live_dec       = live_total_reg - CW'(1);

    assign dp_status.need_reuse = (op_reg == OP_CREATE) && create_pop;
    assign dp_status.out_stall  = rsp_valid_reg && !rsp_ready;

    // The generation read goes to the request's index, or to the index
    // popped from the queue when a create reuses one.
    assign gen_re    = cmd.accept || cmd.reuse_rd;
    assign gen_raddr = cmd.reuse_rd ? fifo_rd_reg : req_handle[IW-1:0];

    // Write-back of one request.
    always_comb
    begin
        fifo_head_next  = fifo_head_reg;
        fifo_tail_next  = fifo_tail_reg;
        fifo_count_next = fifo_count_reg;
        fresh_next_next = fresh_next_reg;
        live_total_next = live_total_reg;
        rsp_handle_next = '0;
        rsp_alive_next  = 1'b0;
        rsp_status_next = ST_OK;
        gen_we          = 1'b0;
        gen_waddr       = req_idx;
        gen_wdata       = gen_rd_reg + GW'(1);
        fifo_we         = 1'b0;
        case (op_reg)
            OP_CREATE:
            begin
                if (create_pop)
                begin
                    // The generation of the popped index was read in the extra step.
                    fifo_head_next  = fifo_head_reg + IW'(1);
                    fifo_count_next = fifo_count_reg - CW'(1);
                    live_total_next = live_total_reg + CW'(1);
                    rsp_handle_next = {gen_rd_reg, fifo_rd_reg};
                end
                else if (fresh_avail)
                begin
                    gen_we          = 1'b1;
                    gen_waddr       = fresh_next_reg[IW-1:0];
                    gen_wdata       = '0;
                    fresh_next_next = fresh_next_reg + CW'(1);
                    live_total_next = live_total_reg + CW'(1);
                    rsp_handle_next = {{GW{1'b0}}, fresh_next_reg[IW-1:0]};
                end
                else
                begin
                    rsp_status_next = ST_NO_INDEX;
                end
            end
            OP_DESTROY:
            begin
                if (!handle_alive)
                begin
                    rsp_status_next = ST_NOT_ALIVE;
                end
                else
                begin
                    gen_we = 1'b1;
                    if (live_dec != '0)
                    begin
                        live_total_next = live_dec;
                        if (fifo_count_reg < SLOT_COUNT)
                        begin
                            fifo_we         = 1'b1;
                            fifo_tail_next  = fifo_tail_reg + IW'(1);
                            fifo_count_next = fifo_count_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        // Last live handle gone: start over from index zero.
                        fifo_head_next  = '0;
                        fifo_tail_next  = '0;
                        fifo_count_next = '0;
                        fresh_next_next = '0;
                        live_total_next = '0;
                    end
                end
            end
            OP_QUERY:
            begin
                rsp_alive_next = handle_alive;
            end
            default:
            begin
                // Clear all.
                fifo_head_next  = '0;
                fifo_tail_next  = '0;
                fifo_count_next = '0;
                fresh_next_next = '0;
                live_total_next = '0;
            end
        endcase
    end

    // Generation memory: one write and one read port, read data registered.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && gen_we)
        begin
            gen_mem[gen_waddr] <= gen_wdata;
        end
        if (gen_re)
        begin
            gen_rd_reg <= gen_mem[gen_raddr];
        end
    end

    // Free-index queue memory: push at the tail, read at the head.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && fifo_we)
        begin
            fifo_mem[fifo_tail_reg] <= req_idx;
        end
        if (cmd.accept)
        begin
            fifo_rd_reg <= fifo_mem[fifo_head_reg];
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg     <= req_opcode;
            handle_reg <= req_handle;
        end
        if (cmd.commit)
        begin
            rsp_handle_reg <= rsp_handle_next;
            rsp_alive_reg  <= rsp_alive_next;
            rsp_status_reg <= rsp_status_next;
            rsp_live_reg   <= live_total_next;
        end
    end

    // Control state: counters, threshold and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_head_reg  <= '0;
            fifo_tail_reg  <= '0;
            fifo_count_reg <= '0;
            fresh_next_reg <= '0;
            live_total_reg <= '0;
            threshold_reg  <= THRESH_RESET;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                fifo_head_reg  <= fifo_head_next;
                fifo_tail_reg  <= fifo_tail_next;
                fifo_count_reg <= fifo_count_next;
                fresh_next_reg <= fresh_next_next;
                live_total_reg <= live_total_next;
            end
            if (cfg_valid)
            begin
                threshold_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign rsp_handle     = rsp_handle_reg;
    assign rsp_is_alive   = rsp_alive_reg;
    assign rsp_status     = rsp_status_reg;
    assign rsp_live_count = rsp_live_reg;

endmodule

FILE: rtl/core/generational_handle_allocator.sv
// Top level of the generational handle allocator: controller plus datapath.
// Depends on gha_pkg, gha_ifs, gha_ctrl and gha_datapath.
//
//  Channel  Role  Payload                                      Transfer when
//  cfg      sink  reuse_threshold                              valid && ready
//  req      sink  opcode, handle_in                            valid && ready
//  rsp      src   handle_out, is_alive, status, live_count     valid && ready
//
// A request is accepted with its memory reads, then decided and written back.
// A create that reuses a freed index takes an extra step, as the generation of
// the popped index needs a second read of the generation memory port.
// Reset clears counters and pointers at once; the memories are not swept.
// A request is taken while a result waits in the output register; it then
// holds before write-back until that register is free.
module generational_handle_allocator import gha_pkg::*; #(
    parameter int INDEX_WIDTH = 12,
    parameter int GEN_WIDTH   = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    gha_cfg_if.sink   cfg,
    gha_req_if.sink   req,
    gha_rsp_if.source rsp
);

    gha_cmd_t       cmd;
    gha_dp_status_t dp_status;
    logic           req_ready;

    // Configuration writes are taken at any time.
    assign cfg.ready = 1'b1;
    assign req.ready = req_ready;

    gha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    gha_datapath #(
        .INDEX_WIDTH (INDEX_WIDTH),
        .GEN_WIDTH   (GEN_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .dp_status      (dp_status),
        .req_opcode     (req.opcode),
        .req_handle     (req.handle_in),
        .cfg_valid      (cfg.valid),
        .cfg_data       (cfg.reuse_threshold),
        .rsp_ready      (rsp.ready),
        .rsp_valid      (rsp.valid),
        .rsp_handle     (rsp.handle_out),
        .rsp_is_alive   (rsp.is_alive),
        .rsp_status     (rsp.status),
        .rsp_live_count (rsp.live_count)
    );

endmodule

FILE: rtl/core/gha_checker.sv
// Port-level checker of the handle allocator, bound to the top level.
// Depends on gha_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gha_checker import gha_pkg::*; #(
    parameter int INDEX_WIDTH = 12,
    parameter int GEN_WIDTH   = 8
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_ready,
    input logic                             rsp_valid,
    input logic                             rsp_ready,
    input logic [INDEX_WIDTH+GEN_WIDTH-1:0] rsp_handle,
    input logic                             rsp_is_alive,
    input gha_status_code_t                 rsp_status,
    input logic [INDEX_WIDTH:0]             rsp_live_count
);

    localparam logic [INDEX_WIDTH:0] SLOT_COUNT = {1'b1, {INDEX_WIDTH{1'b0}}};

    // Requests are never taken back to back.
    `GHA_ASSERT_NEXT(a_req_two_cycles, clk, rst_n, req_valid && req_ready, !req_ready, "request taken in back-to-back cycles")

    // A failed request returns no handle and no liveness.
    `GHA_ASSERT_SAME(a_fail_empty, clk, rst_n, rsp_valid && (rsp_status != ST_OK), (rsp_handle == '0) && !rsp_is_alive, "failed request carries a handle or liveness")

    // A positive query answer is never paired with a handle or an error.
    `GHA_ASSERT_SAME(a_alive_clean, clk, rst_n, rsp_valid && rsp_is_alive, (rsp_status == ST_OK) && (rsp_handle == '0), "query answer mixed with other results")

    // The live count never exceeds the number of indices.
    `GHA_ASSERT_SAME(a_live_bound, clk, rst_n, rsp_valid, rsp_live_count <= SLOT_COUNT, "live count above index space")

    // A stalled result holds until its transfer.
    `GHA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_handle) && $stable(rsp_live_count), "stalled result changed")

endmodule

bind generational_handle_allocator gha_checker #(
    .INDEX_WIDTH (INDEX_WIDTH),
    .GEN_WIDTH   (GEN_WIDTH)
) u_gha_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_handle     (rsp.handle_out),
    .rsp_is_alive   (rsp.is_alive),
    .rsp_status     (rsp.status),
    .rsp_live_count (rsp.live_count)
);
